// ===== rtl/sspg_pkg.sv =====
// sspg_pkg: shared types and constants for the step/direction pulse generator
// no dependencies; used by the interfaces, the engine and the top level
`default_nettype none

package sspg_pkg;

	localparam int CmdWidth     = 3;
	localparam int TargetWidth  = 15;
	localparam int DividerWidth = 7;
	localparam int TickWidth    = 8;
	localparam int CountWidth   = 16;

	typedef enum logic [CmdWidth-1:0] {
		CMD_TICK     = 3'd0,
		CMD_STOP     = 3'd1,
		CMD_RUN_FWD  = 3'd2,
		CMD_RUN_BWD  = 3'd3,
		CMD_MOVE_FWD = 3'd4,
		CMD_MOVE_BWD = 3'd5
	} cmd_t;

	typedef struct packed {
		logic                         step_clock;
		logic                         dir_level;
		logic                         running;
		logic signed [CountWidth-1:0] prior_count;
		logic signed [CountWidth-1:0] edge_count;
		logic                         move_done;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/sspg_if.sv =====
// sspg_if: valid/ready channel interfaces for commands, results and the divider register
// depends on sspg_pkg for the field widths
`default_nettype none

interface sspg_cmd_if import sspg_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CmdWidth-1:0]    command;
	logic [TargetWidth-1:0] step_target;

	modport source (output valid, output command, output step_target, input ready);
	modport sink (input valid, input command, input step_target, output ready);
endinterface

interface sspg_res_if import sspg_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         step_clock;
	logic                         dir_level;
	logic                         running;
	logic signed [CountWidth-1:0] prior_count;
	logic signed [CountWidth-1:0] edge_count;
	logic                         move_done;

	modport source (output valid, output step_clock, output dir_level, output running,
		output prior_count, output edge_count, output move_done, input ready);
	modport sink (input valid, input step_clock, input dir_level, input running,
		input prior_count, input edge_count, input move_done, output ready);
endinterface

interface sspg_cfg_if import sspg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [DividerWidth-1:0] divider;

	modport source (output valid, output divider, input ready);
	modport sink (input valid, input divider, output ready);
endinterface

`default_nettype wire

// ===== rtl/sspg_engine.sv =====
// sspg_engine: motion state registers and the per-transaction next-state and result logic
// depends on sspg_pkg
`default_nettype none

module sspg_engine import sspg_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step_en,
	input  wire logic [CmdWidth-1:0]     command,
	input  wire logic [TargetWidth-1:0]  step_target,
	input  wire logic [DividerWidth-1:0] divider,
	output result_t                      result
);

	logic [TickWidth-1:0]  tick_q, tick_d;
	logic [CountWidth-1:0] edges_q, edges_d;
	logic [CountWidth-1:0] target_q, target_d;
	logic                  down_q, down_d;
	logic                  run_q, run_d;
	logic                  clk_lvl_q, clk_lvl_d;
	logic                  dir_q, dir_d;
	logic [CountWidth-1:0] prior;
	logic                  done;
	logic                  div_match;
	logic                  target_hit;

	assign div_match  = (tick_q == {1'b0, divider});
	assign target_hit = (target_q != '0) && ($signed(target_q) <= $signed(edges_q));

	always_comb begin
		tick_d    = tick_q;
		edges_d   = edges_q;
		target_d  = target_q;
		down_d    = down_q;
		run_d     = run_q;
		clk_lvl_d = clk_lvl_q;
		dir_d     = dir_q;
		prior     = '0;
		done      = 1'b0;
		case (cmd_t'(command))
			CMD_STOP: begin
				prior     = edges_q;
				clk_lvl_d = 1'b0;
				run_d     = 1'b0;
				edges_d   = '0;
				target_d  = '0;
			end
			CMD_RUN_FWD, CMD_RUN_BWD: begin
				prior     = edges_q;
				clk_lvl_d = 1'b0;
				edges_d   = '0;
				target_d  = '0;
				dir_d     = (cmd_t'(command) == CMD_RUN_FWD);
				down_d    = (cmd_t'(command) == CMD_RUN_BWD);
				run_d     = 1'b1;
			end
			CMD_MOVE_FWD, CMD_MOVE_BWD: begin
				prior     = edges_q;
				clk_lvl_d = 1'b0;
				edges_d   = '0;
				dir_d     = (cmd_t'(command) == CMD_MOVE_FWD);
				down_d    = 1'b0;
				target_d  = {1'b0, step_target};
				run_d     = (step_target != '0);
			end
			default: begin
				// tick, and the unused codes behave as a tick
				if (run_q) begin
					if (div_match) begin
						if (target_hit) begin
							target_d  = '0;
							prior     = edges_q;
							clk_lvl_d = 1'b0;
							run_d     = 1'b0;
							edges_d   = '0;
							done      = 1'b1;
						end else begin
							clk_lvl_d = ~clk_lvl_q;
							tick_d    = '0;
							edges_d   = down_q ? edges_q - 1'b1 : edges_q + 1'b1;
						end
					end else begin
						tick_d = tick_q + 1'b1;
					end
				end
			end
		endcase
	end

	always_comb begin
		result.step_clock  = clk_lvl_d;
		result.dir_level   = dir_d;
		result.running     = run_d;
		result.prior_count = prior;
		result.edge_count  = edges_d;
		result.move_done   = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			edges_q   <= '0;
			target_q  <= '0;
			down_q    <= 1'b0;
			run_q     <= 1'b0;
			clk_lvl_q <= 1'b0;
			dir_q     <= 1'b0;
		end else if (step_en) begin
			tick_q    <= tick_d;
			edges_q   <= edges_d;
			target_q  <= target_d;
			down_q    <= down_d;
			run_q     <= run_d;
			clk_lvl_q <= clk_lvl_d;
			dir_q     <= dir_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stepper_step_pulse_generator.sv =====
// stepper_step_pulse_generator: top level with input register, engine and result register
// depends on sspg_pkg, the sspg interfaces and sspg_engine
`default_nettype none

// Step/direction pulse generator. Each command transaction carries a tick (one timer
// compare match) or a motion command, and yields exactly one result transaction with the
// pin levels, the running flag and the edge counts. A transaction passes an input register
// and then the result register, from which its result is offered on the res channel, and
// one transaction is taken every cycle as long as results are taken. The engine computes
// the state update between those two registers. The divider register is written through
// the cfg channel, which is always ready; write it only while idle.
module stepper_step_pulse_generator import sspg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sspg_cmd_if.sink   cmd,
	sspg_res_if.source res,
	sspg_cfg_if.sink   cfg
);

	logic                    valid_s1;
	logic [CmdWidth-1:0]     command_s1;
	logic [TargetWidth-1:0]  target_s1;
	logic                    valid_s2;
	result_t                 result_s2;
	result_t                 result_d;
	logic [DividerWidth-1:0] divider_q;
	logic                    s2_free;
	logic                    s1_advance;
	logic                    s1_load;

	assign s2_free    = !valid_s2 || res.ready;
	assign s1_advance = valid_s1 && s2_free;
	assign cmd.ready  = !valid_s1 || s2_free;
	assign s1_load    = cmd.valid && cmd.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= '0;
		end else if (cfg.valid) begin
			divider_q <= cfg.divider;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			command_s1 <= cmd.command;
			target_s1  <= cmd.step_target;
		end
		if (s1_advance) begin
			result_s2 <= result_d;
		end
	end

	sspg_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (s1_advance),
		.command     (command_s1),
		.step_target (target_s1),
		.divider     (divider_q),
		.result      (result_d)
	);

	assign res.valid       = valid_s2;
	assign res.step_clock  = result_s2.step_clock;
	assign res.dir_level   = result_s2.dir_level;
	assign res.running     = result_s2.running;
	assign res.prior_count = result_s2.prior_count;
	assign res.edge_count  = result_s2.edge_count;
	assign res.move_done   = result_s2.move_done;

endmodule

`default_nettype wire

// ===== rtl/sspg_checker.sv =====
// sspg_checker: port-level assertions for the pulse generator, bound to the top level
// depends on sspg_pkg
`default_nettype none

module sspg_checker import sspg_pkg::*; (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         res_valid,
	input wire logic                         res_ready,
	input wire logic                         step_clock,
	input wire logic                         dir_level,
	input wire logic                         running,
	input wire logic signed [CountWidth-1:0] prior_count,
	input wire logic signed [CountWidth-1:0] edge_count,
	input wire logic                         move_done
);

	// a finished move leaves the generator stopped with a cleared count
	a_done_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && move_done |-> !running && !step_clock && edge_count == '0)
		else $error("move_done without halt");

	// a move only completes after at least one edge was counted
	a_done_prior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && move_done |-> prior_count > 0)
		else $error("move_done with non-positive prior count");

	// while stopped the step clock is low and the count is clear
	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !running |-> !step_clock && edge_count == '0)
		else $error("stopped with clock high or count set");

	// a stalled result transaction holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(step_clock) && $stable(dir_level)
			&& $stable(running) && $stable(prior_count) && $stable(edge_count)
			&& $stable(move_done))
		else $error("result changed while stalled");

endmodule

bind stepper_step_pulse_generator sspg_checker u_sspg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.step_clock  (res.step_clock),
	.dir_level   (res.dir_level),
	.running     (res.running),
	.prior_count (res.prior_count),
	.edge_count  (res.edge_count),
	.move_done   (res.move_done)
);

`default_nettype wire

// ===== test/stepper_step_pulse_generator_tb.sv =====
// testbench for stepper_step_pulse_generator: directed table, then random phases
// needs sspg_pkg, the sspg interfaces and the rtl top level; checks every result transaction
// against a cycle-free model of the tick counter, edge count and pin levels
`timescale 1ns / 100ps

module stepper_step_pulse_generator_tb;
	import sspg_pkg::*;

	localparam logic [CmdWidth-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CmdWidth-1:0] CMD_SPARE_HI = 3'd7;
	localparam int Phases     = 10;
	localparam int PhaseItems = 145;

	typedef struct {
		logic [CmdWidth-1:0]    command;
		logic [TargetWidth-1:0] step_target;
		bit                     fixed;
		result_t                outcome;
	} script_row_t;

	logic clk;
	logic arst_n;

	sspg_cmd_if cmd_ch ();
	sspg_res_if res_ch ();
	sspg_cfg_if cfg_ch ();

	stepper_step_pulse_generator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// model of the generator state
	logic [DividerWidth-1:0] gen_divider;
	logic [TickWidth-1:0]    gen_ticks;
	logic [CountWidth-1:0]   gen_edges;
	logic [CountWidth-1:0]   gen_target;
	logic                    gen_down;
	logic                    gen_run;
	logic                    gen_clk;
	logic                    gen_dir;

	result_t     results_due[$];
	script_row_t script[$];
	int          err_cnt = 0;
	bit          sender_idles = 1'b1;
	bit          receiver_idles = 1'b1;

	function automatic logic [CountWidth-1:0] halt_motion();
		logic [CountWidth-1:0] reached;
		reached = gen_edges;
		gen_clk = 1'b0;
		gen_run = 1'b0;
		gen_edges = '0;
		return reached;
	endfunction

	function automatic result_t advance_generator(input logic [CmdWidth-1:0] c,
			input logic [TargetWidth-1:0] t);
		result_t               r;
		logic [CountWidth-1:0] prior;
		logic                  done;
		prior = '0;
		done = 1'b0;
		case (c)
			CMD_STOP: begin
				prior = halt_motion();
				gen_target = '0;
			end
			CMD_RUN_FWD, CMD_RUN_BWD: begin
				prior = halt_motion();
				gen_target = '0;
				gen_dir = (c == CMD_RUN_FWD);
				gen_down = (c == CMD_RUN_BWD);
				gen_run = 1'b1;
			end
			CMD_MOVE_FWD, CMD_MOVE_BWD: begin
				prior = halt_motion();
				gen_dir = (c == CMD_MOVE_FWD);
				gen_down = 1'b0;
				gen_target = {1'b0, t};
				gen_run = (t != '0);
			end
			default: begin
				// ticks and the spare codes
				if (gen_run) begin
					if (gen_ticks == {1'b0, gen_divider}) begin
						if (gen_target != '0 && $signed(gen_target) <= $signed(gen_edges)) begin
							gen_target = '0;
							prior = halt_motion();
							done = 1'b1;
						end else begin
							gen_clk = !gen_clk;
							gen_ticks = '0;
							gen_edges = gen_down ? gen_edges - 16'd1 : gen_edges + 16'd1;
						end
					end else begin
						gen_ticks = gen_ticks + 8'd1;
					end
				end
			end
		endcase
		r.step_clock = gen_clk;
		r.dir_level = gen_dir;
		r.running = gen_run;
		r.prior_count = prior;
		r.edge_count = gen_edges;
		r.move_done = done;
		return r;
	endfunction

	function automatic result_t pins(input logic sc, input logic dl, input logic rn,
			input logic signed [CountWidth-1:0] pc, input logic signed [CountWidth-1:0] ec,
			input logic md);
		result_t r;
		r.step_clock = sc;
		r.dir_level = dl;
		r.running = rn;
		r.prior_count = pc;
		r.edge_count = ec;
		r.move_done = md;
		return r;
	endfunction

	function automatic void add_row(input logic [CmdWidth-1:0] c,
			input logic [TargetWidth-1:0] t, input bit fixed = 1'b0, input result_t r = '0);
		script_row_t row;
		row.command = c;
		row.step_target = t;
		row.fixed = fixed;
		row.outcome = r;
		script.push_back(row);
	endfunction

	task automatic push_item(input logic [CmdWidth-1:0] c, input logic [TargetWidth-1:0] t,
			input bit fixed = 1'b0, input result_t outcome = '0);
		result_t want;
		while (sender_idles && $urandom_range(99) < 18) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.step_target <= t;
		do @(posedge clk); while (!cmd_ch.ready);
		want = advance_generator(c, t);
		results_due.push_back(fixed ? outcome : want);
	endtask

	// hold off commands until every outstanding result has come back
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_divider(input logic [DividerWidth-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.divider <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		gen_divider = d;
	endtask

	task automatic compare_field(input string field, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			err_cnt++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= !(receiver_idles && $urandom_range(99) < 18);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				$error("result transaction with nothing expected");
				err_cnt++;
			end else begin
				want = results_due.pop_front();
				compare_field("step_clock", 32'(want.step_clock), 32'(res_ch.step_clock));
				compare_field("dir_level", 32'(want.dir_level), 32'(res_ch.dir_level));
				compare_field("running", 32'(want.running), 32'(res_ch.running));
				compare_field("prior_count", 32'(want.prior_count), 32'(res_ch.prior_count));
				compare_field("edge_count", 32'(want.edge_count), 32'(res_ch.edge_count));
				compare_field("move_done", 32'(want.move_done), 32'(res_ch.move_done));
			end
		end
	end

	initial begin
		logic [CmdWidth-1:0]    c;
		logic [TargetWidth-1:0] t;
		int                     pick;
		int                     sel;
		int                     active;
		int                     n;

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_TICK;
		cmd_ch.step_target <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.divider <= '0;

		gen_divider = '0;
		gen_ticks = '0;
		gen_edges = '0;
		gen_target = '0;
		gen_down = 1'b0;
		gen_run = 1'b0;
		gen_clk = 1'b0;
		gen_dir = 1'b0;

		// directed part, divider at its reset value of zero
		add_row(CMD_TICK, '0, 1'b1, pins(1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0));
		add_row(CMD_STOP, '1, 1'b1, pins(1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0));
		add_row(CMD_MOVE_BWD, '0, 1'b1, pins(1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0));
		add_row(CMD_MOVE_FWD, '0, 1'b1, pins(1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0, 1'b0));
		add_row(CMD_RUN_FWD, 15'h5555, 1'b1, pins(1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0));
		add_row(CMD_TICK, '0);
		add_row(CMD_TICK, 15'h2aaa);
		add_row(CMD_TICK, '0);
		add_row(CMD_RUN_BWD, '0);
		add_row(CMD_TICK, '0);
		add_row(CMD_TICK, '0);
		add_row(CMD_SPARE_LO, '0);
		add_row(CMD_SPARE_HI, '1);
		add_row(CMD_MOVE_FWD, 15'd2);
		add_row(CMD_TICK, '0);
		add_row(CMD_TICK, '0);
		add_row(CMD_TICK, '0);
		add_row(CMD_TICK, '0);
		add_row(CMD_MOVE_BWD, 15'd1);
		add_row(CMD_TICK, '0);
		add_row(CMD_TICK, '0);
		add_row(CMD_MOVE_FWD, '1);
		add_row(CMD_TICK, '0);
		add_row(CMD_TICK, '0);
		add_row(CMD_STOP, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			push_item(script[i].command, script[i].step_target, script[i].fixed,
				script[i].outcome);

		for (int p = 0; p < Phases; p++) begin
			settle();
			if (p == 0)
				write_divider('1);
			else if (p == 1)
				write_divider('0);
			else if ($urandom_range(2) == 0)
				write_divider(DividerWidth'($urandom_range(127)));
			else
				write_divider(DividerWidth'($urandom_range(7)));
			sender_idles = (p != 5);
			receiver_idles = (p != 5);
			active = 0;
			n = 0;
			while (active < PhaseItems) begin
				pick = $urandom_range(99);
				t = TargetWidth'($urandom_range(32767));
				// stopped ticks do nothing, so mostly start something instead
				if (!gen_run && pick < 70 && $urandom_range(3) != 0)
					pick = 70 + $urandom_range(29);
				if (pick < 70) begin
					c = CMD_TICK;
				end else if (pick < 74) begin
					c = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
				end else if (pick < 80) begin
					c = CMD_STOP;
				end else if (pick < 86) begin
					c = pick[0] ? CMD_RUN_BWD : CMD_RUN_FWD;
				end else begin
					c = pick[0] ? CMD_MOVE_BWD : CMD_MOVE_FWD;
					sel = $urandom_range(9);
					if (sel == 0)
						t = '0;
					else if (sel < 8)
						t = TargetWidth'($urandom_range(12, 1));
				end
				if (gen_run || (c inside {[CMD_STOP:CMD_MOVE_BWD]}))
					active++;
				push_item(c, t);
				n++;
				if (p == 3 && n == 60)
					settle();
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
